/* rtl/wildcard_pattern_matcher_defines.svh */
// Assertion macros for the checker file of the wildcard pattern matcher.
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wildcard_pattern_matcher: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wildcard_pattern_matcher: next-cycle check failed");

`endif

/* rtl/wpm_pkg.sv */
// Shared types and constants of the wildcard pattern matcher.
package wpm_pkg;

    localparam int SYMBOL_W = 8;
    localparam int INDEX_W  = 6;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 7;

    localparam logic [SYMBOL_W-1:0] WILDCARD = 8'd63;

    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    typedef struct packed {
        logic                write;
        logic                step;
        logic [INDEX_W-1:0]  index;
        logic [SYMBOL_W-1:0] symbol;
    } wpm_ctrl_t;

endpackage

/* rtl/wpm_match_array.sv */
// Pattern store, per-position compare lanes and the shift-and partial match vector.
module wpm_match_array
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int IDX_W       = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  wpm_ctrl_t        ctrl,
    input  logic [IDX_W-1:0] tail_sel,
    output logic             tail_hit
);

    logic [SYMBOL_W-1:0]    store_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] vec_reg;
    logic [MAX_PATTERN-1:0] vec_next;
    logic [MAX_PATTERN-1:0] hit;

    genvar i;
    generate
        for (i = 0; i < MAX_PATTERN; i++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (ctrl.write && (32'(ctrl.index) == i))
                begin
                    store_reg[i] <= ctrl.symbol;
                end
            end

            assign hit[i] = (store_reg[i] == WILDCARD) || (store_reg[i] == ctrl.symbol);

            if (i == 0)
            begin : g_head
                assign vec_next[i] = hit[i];
            end
            else
            begin : g_body
                assign vec_next[i] = vec_reg[i-1] & hit[i];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= '0;
        end
        else if (ctrl.write)
        begin
            vec_reg <= '0;
        end
        else if (ctrl.step)
        begin
            vec_reg <= vec_next;
        end
    end

    assign tail_hit = vec_next[tail_sel];

endmodule

/* rtl/wildcard_pattern_matcher.sv */
// Top level of the wildcard pattern matcher: handshakes, position counter and result register.
//
//   channel  | signals                                   | moves
//   ---------+-------------------------------------------+------------------------------
//   in       | in_valid, in_ready, func, pattern_index,  | one pattern byte or text byte
//            | symbol                                    |
//   out      | out_valid, out_ready, match_position      | one match start position
//   cfg      | cfg_we, cfg_data                          | pattern_length, no wait
//
// An accepted item sits in the input register, and the compare stage between that register
// and the result register finishes it when the input stage moves on, so a result is offered
// once its text byte has passed both registers; one item is taken every cycle while no result
// waits downstream. The parallel compare lanes form a single stage.
// Reset clears the partial match vector, the position counter and the length
// register; pattern bytes are undefined until written. A stalled result holds the
// input register, and a new item is still taken while the result register drains.
module wildcard_pattern_matcher
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = 64
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [INDEX_W-1:0]  pattern_index,
    input  logic [SYMBOL_W-1:0] symbol,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [POS_W-1:0]    match_position
);

    // Index width into the vector and width of the clamped length.
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Configuration register.
    logic [CFG_W-1:0]    pattern_length_reg;

    // Input register.
    logic                s1_valid_reg;
    logic                s1_func_reg;
    logic [INDEX_W-1:0]  s1_index_reg;
    logic [SYMBOL_W-1:0] s1_symbol_reg;

    // Text position and result register.
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [POS_W-1:0]    match_position_reg;
    logic [POS_W-1:0]    match_position_next;

    logic                in_accept;
    logic                s1_go;
    logic                write_ok;
    logic                text_go;
    logic                fire;
    logic [LEN_W-1:0]    len;
    logic [IDX_W-1:0]    tail_sel;
    logic                tail_hit;
    wpm_ctrl_t           ctrl;

    // The input stage moves on whenever the result register is empty or being
    // taken, so the block only stalls while a result waits downstream.
    assign s1_go     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_go;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            pattern_length_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg   <= func;
            s1_index_reg  <= pattern_index;
            s1_symbol_reg <= symbol;
        end
    end

    // A pattern write outside the store is dropped entirely, clearing nothing.
    assign write_ok = s1_go && (s1_func_reg == FUNC_PATTERN)
                      && (32'(s1_index_reg) < MAX_PATTERN);
    assign text_go  = s1_go && (s1_func_reg == FUNC_TEXT);

    assign ctrl.write  = write_ok;
    assign ctrl.step   = text_go;
    assign ctrl.index  = s1_index_reg;
    assign ctrl.symbol = s1_symbol_reg;

    // Lengths beyond the store act as the full store.
    always_comb
    begin
        if (32'(pattern_length_reg) > MAX_PATTERN)
        begin
            len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len = LEN_W'(pattern_length_reg);
        end
    end

    assign tail_sel = IDX_W'(len - LEN_W'(1));

    wpm_match_array #(
        .MAX_PATTERN (MAX_PATTERN),
        .IDX_W       (IDX_W)
    ) u_array (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .tail_sel (tail_sel),
        .tail_hit (tail_hit)
    );

    // A zero length reports every text byte at its own index; otherwise a hit on
    // the last pattern position reports the window start.
    assign fire = text_go && ((len == '0) || tail_hit);

    always_comb
    begin
        if (len == '0)
        begin
            match_position_next = pos_reg;
        end
        else
        begin
            match_position_next = pos_reg - POS_W'(tail_sel);
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (write_ok)
        begin
            pos_next = '0;
        end
        else if (text_go)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            match_position_reg <= match_position_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign match_position = match_position_reg;

endmodule

/* rtl/wpm_checker.sv */
// Port-level assertion checker for the wildcard pattern matcher, bound to the top level.
`include "wildcard_pattern_matcher_defines.svh"

module wpm_checker
    import wpm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [POS_W-1:0]    match_position
);

    // A waiting result keeps its value until taken.
    `WPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(match_position))

    // With no result pending, nothing can hold back the input side.
    `WPM_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready)

    // A rising result follows an accepted item that passed the input register, then the result register.
    `WPM_ASSERT_NOW(a_result_has_item, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (.*);
